FILE: sv/rei_pkg.sv
package rei_pkg;

  // Field widths
  localparam int unsigned COORD_W  = 32;
  localparam int unsigned STEP_W   = 31;
  localparam int unsigned WARM_W   = 24;
  localparam int unsigned DECIM_W  = 16;
  localparam int unsigned CIDX_W   = 3;
  localparam int unsigned PROD_W   = 64;

  // Input function codes
  localparam logic FUNC_SEED = 1'b0;
  localparam logic FUNC_STEP = 1'b1;

  // Configuration register indexes
  localparam logic [CIDX_W-1:0] CFG_STEP_SIZE = 3'd0;
  localparam logic [CIDX_W-1:0] CFG_COEF_A    = 3'd1;
  localparam logic [CIDX_W-1:0] CFG_COEF_B    = 3'd2;
  localparam logic [CIDX_W-1:0] CFG_COEF_C    = 3'd3;
  localparam logic [CIDX_W-1:0] CFG_WARMUP    = 3'd4;
  localparam logic [CIDX_W-1:0] CFG_DECIM     = 3'd5;

  // Reset values of the counting registers
  localparam logic [WARM_W-1:0]  WARMUP_RST = 24'd10000;
  localparam logic [DECIM_W-1:0] DECIM_RST  = 16'd100;

  // Signed 32-bit limits, held at product width
  localparam logic signed [PROD_W-1:0] S32_MAX = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [PROD_W-1:0] S32_MIN = 64'shFFFF_FFFF_8000_0000;

  // Controller states, one per sequencer step
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_D1,
    ST_AY,
    ST_UX,
    ST_D2,
    ST_ZC,
    ST_UY,
    ST_D3,
    ST_MW,
    ST_UZ
  } state_t;

  // Datapath operations
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LD_D1,
    OP_LD_AY,
    OP_UPD_X,
    OP_LD_D2,
    OP_LD_ZC,
    OP_UPD_Y,
    OP_LD_D3,
    OP_UPD_Z
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   seed;
    logic   commit;
  } cmd_t;

  typedef struct packed {
    logic emit;
    logic out_free;
  } stat_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] val;
    logic                      ovf;
  } sat_t;

  // Sign extend a coordinate to product width
  function automatic logic signed [PROD_W-1:0] sx(input logic signed [COORD_W-1:0] v);
    return {{(PROD_W-COORD_W){v[COORD_W-1]}}, v};
  endfunction

  // Clamp to the signed 32-bit range, flag when clamped
  function automatic sat_t sat32(input logic signed [PROD_W-1:0] v);
    sat_t r;
    r.ovf = 1'b1;
    if (v > S32_MAX) begin
      r.val = 32'sh7FFF_FFFF;
    end else if (v < S32_MIN) begin
      r.val = 32'sh8000_0000;
    end else begin
      r.val = v[COORD_W-1:0];
      r.ovf = 1'b0;
    end
    return r;
  endfunction

endpackage

FILE: sv/rei_ctrl.sv
module rei_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic           func,
  output logic           in_stall,
  input  rei_pkg::stat_t stat,
  output rei_pkg::cmd_t  cmd
);
  import rei_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid && func == FUNC_STEP) state_next = ST_D1;
      end
      ST_D1: state_next = ST_AY;
      ST_AY: state_next = ST_UX;
      ST_UX: state_next = ST_D2;
      ST_D2: state_next = ST_ZC;
      ST_ZC: state_next = ST_UY;
      ST_UY: state_next = ST_D3;
      ST_D3: state_next = ST_MW;
      ST_MW: state_next = ST_UZ;
      ST_UZ: begin
        // hold the finished step until the output register can take it
        if (!stat.emit || stat.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_stall   = 1'b1;
    cmd.op     = OP_NONE;
    cmd.seed   = 1'b0;
    cmd.commit = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.seed = in_valid && func == FUNC_SEED;
      end
      ST_D1: cmd.op = OP_LD_D1;
      ST_AY: cmd.op = OP_LD_AY;
      ST_UX: cmd.op = OP_UPD_X;
      ST_D2: cmd.op = OP_LD_D2;
      ST_ZC: cmd.op = OP_LD_ZC;
      ST_UY: cmd.op = OP_UPD_Y;
      ST_D3: cmd.op = OP_LD_D3;
      ST_MW: cmd.op = OP_NONE;
      ST_UZ: begin
        cmd.op     = OP_UPD_Z;
        cmd.commit = !stat.emit || stat.out_free;
      end
      default: cmd.op = OP_NONE;
    endcase
  end

  a_step_start: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE && in_valid && func == FUNC_STEP) |=> state == ST_D1)
    else $error("step transaction did not start the sequence");

  a_commit_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> state == ST_IDLE)
    else $error("sequencer did not return to idle after commit");

  a_hold_last: assert property (@(posedge clk) disable iff (rst)
    (state == ST_UZ && !cmd.commit) |=> state == ST_UZ)
    else $error("last step left while output was blocked");

endmodule

FILE: sv/rei_dp.sv
module rei_dp #(
  parameter int unsigned FRAC_BITS = 24
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  rei_pkg::cmd_t                          cmd,
  output rei_pkg::stat_t                         stat,
  input  logic                                   cfg_we,
  input  logic [rei_pkg::CIDX_W-1:0]             cfg_index,
  input  logic [rei_pkg::COORD_W-1:0]            cfg_data,
  input  logic signed [rei_pkg::COORD_W-1:0]     seed_x,
  input  logic signed [rei_pkg::COORD_W-1:0]     seed_y,
  input  logic signed [rei_pkg::COORD_W-1:0]     seed_z,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [rei_pkg::COORD_W-1:0]     out_x,
  output logic signed [rei_pkg::COORD_W-1:0]     out_y,
  output logic signed [rei_pkg::COORD_W-1:0]     out_z,
  output logic                                   saturated
);
  import rei_pkg::*;

  localparam logic signed [PROD_W-1:0] Q_ONE = 64'sd1 <<< FRAC_BITS;
  localparam logic signed [PROD_W-1:0] HALF  = 64'sd1 <<< (FRAC_BITS - 1);
  localparam logic [STEP_W-1:0]  STEP_RST = STEP_W'(Q_ONE / 100);
  localparam logic signed [COORD_W-1:0] COEF_A_RST = COORD_W'(Q_ONE / 5);
  localparam logic signed [COORD_W-1:0] COEF_B_RST = COORD_W'(Q_ONE / 5);
  localparam logic signed [COORD_W-1:0] COEF_C_RST = COORD_W'((Q_ONE * 57) / 10);

  // Configuration
  logic [STEP_W-1:0]          step_size;
  logic signed [COORD_W-1:0]  coef_a;
  logic signed [COORD_W-1:0]  coef_b;
  logic signed [COORD_W-1:0]  coef_c;
  logic [WARM_W-1:0]          warmup_steps;
  logic [DECIM_W-1:0]         decimation;

  // State
  logic signed [COORD_W-1:0]  pos_x;
  logic signed [COORD_W-1:0]  pos_y;
  logic signed [COORD_W-1:0]  pos_z;
  logic [WARM_W-1:0]          step_count;
  logic [DECIM_W-1:0]         decim_count;
  logic                       sat_flag;

  // Multiplier operands and registered product
  logic signed [COORD_W-1:0]  op_a;
  logic signed [COORD_W-1:0]  op_b;
  logic signed [PROD_W-1:0]   prod;
  logic signed [COORD_W-1:0]  h_op;

  // Shared adder
  sat_t                       q;
  sat_t                       s;
  logic signed [PROD_W-1:0]   add_l;
  logic signed [PROD_W-1:0]   add_r;
  logic                       use_q;
  logic                       hit;

  // Sampling
  logic                       warm;
  logic [DECIM_W-1:0]         period;
  logic [DECIM_W-1:0]         dc;
  logic [DECIM_W:0]           dc_inc;
  logic [DECIM_W-1:0]         decim_next;

  assign h_op = {1'b0, step_size};

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      step_size    <= STEP_RST;
      coef_a       <= COEF_A_RST;
      coef_b       <= COEF_B_RST;
      coef_c       <= COEF_C_RST;
      warmup_steps <= WARMUP_RST;
      decimation   <= DECIM_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_STEP_SIZE: step_size    <= cfg_data[STEP_W-1:0];
        CFG_COEF_A:    coef_a       <= cfg_data;
        CFG_COEF_B:    coef_b       <= cfg_data;
        CFG_COEF_C:    coef_c       <= cfg_data;
        CFG_WARMUP:    warmup_steps <= cfg_data[WARM_W-1:0];
        CFG_DECIM:     decimation   <= cfg_data[DECIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Rounded, clamped product: floor after adding one half
  assign q = sat32(prod >>> FRAC_BITS);

  // Adder operand selection
  always_comb begin
    add_l = '0;
    add_r = '0;
    use_q = 1'b0;
    case (cmd.op) inside
      OP_LD_D1: begin
        add_l = -sx(pos_y);
        add_r = -sx(pos_z);
      end
      OP_UPD_X, OP_LD_D2: begin
        add_l = sx(pos_x);
        add_r = sx(q.val);
        use_q = 1'b1;
      end
      OP_LD_ZC: begin
        add_l = sx(pos_x);
        add_r = -sx(coef_c);
      end
      OP_UPD_Y: begin
        add_l = sx(pos_y);
        add_r = sx(q.val);
        use_q = 1'b1;
      end
      OP_LD_D3: begin
        add_l = sx(coef_b);
        add_r = sx(q.val);
        use_q = 1'b1;
      end
      OP_UPD_Z: begin
        add_l = sx(pos_z);
        add_r = sx(q.val);
        use_q = 1'b1;
      end
      default: ;
    endcase
  end

  assign s   = sat32(add_l + add_r);
  assign hit = (cmd.op != OP_NONE && cmd.op != OP_LD_AY) && (s.ovf || (use_q && q.ovf));

  // Sample selection
  assign warm       = step_count >= warmup_steps;
  assign period     = (decimation == '0) ? DECIM_W'(1) : decimation;
  assign dc         = (decim_count >= period) ? '0 : decim_count;
  assign dc_inc     = {1'b0, dc} + (DECIM_W+1)'(1);
  assign decim_next = (dc_inc >= {1'b0, period}) ? '0 : dc_inc[DECIM_W-1:0];

  assign stat.emit     = warm && dc == '0;
  assign stat.out_free = !out_valid || !out_stall;

  // Shared multiplier, registered with the rounding half
  always_ff @(posedge clk) begin
    prod <= sx(op_a) * sx(op_b) + HALF;
  end

  // Operand loading
  always_ff @(posedge clk) begin
    case (cmd.op) inside
      OP_LD_D1, OP_LD_D2, OP_LD_D3: begin
        op_a <= h_op;
        op_b <= s.val;
      end
      OP_LD_AY: begin
        op_a <= coef_a;
        op_b <= pos_y;
      end
      OP_LD_ZC: begin
        op_a <= pos_z;
        op_b <= s.val;
      end
      default: ;
    endcase
  end

  // Point, counters and flag
  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x       <= '0;
      pos_y       <= '0;
      pos_z       <= '0;
      step_count  <= '0;
      decim_count <= '0;
      sat_flag    <= 1'b0;
    end else if (cmd.seed) begin
      pos_x       <= seed_x;
      pos_y       <= seed_y;
      pos_z       <= seed_z;
      step_count  <= '0;
      decim_count <= '0;
      sat_flag    <= 1'b0;
    end else begin
      if (cmd.op == OP_UPD_X) pos_x <= s.val;
      if (cmd.op == OP_UPD_Y) pos_y <= s.val;
      if (cmd.op != OP_UPD_Z || cmd.commit) sat_flag <= sat_flag | hit;
      if (cmd.commit) begin
        pos_z <= s.val;
        if (step_count != '1) step_count <= step_count + WARM_W'(1);
        if (warm) decim_count <= decim_next;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit && stat.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && stat.emit) begin
      out_x     <= pos_x;
      out_y     <= pos_y;
      out_z     <= s.val;
      saturated <= sat_flag | hit;
    end
  end

  a_emit_out: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && stat.emit) |=> out_valid)
    else $error("sampled step produced no output");

  a_seed_clear: assert property (@(posedge clk) disable iff (rst)
    cmd.seed |=> (step_count == '0 && decim_count == '0 && !sat_flag))
    else $error("seed did not clear counters");

  a_count_mono: assert property (@(posedge clk) disable iff (rst)
    !cmd.seed |=> step_count >= $past(step_count))
    else $error("step count went backward without a seed");

endmodule

FILE: sv/rossler_euler_integrator.sv
// Channel  | handshake              | payload
// ---------+------------------------+------------------------------------
// in       | in_valid / in_stall    | func, seed_x, seed_y, seed_z
// out      | out_valid / out_stall  | out_x, out_y, out_z, saturated
// cfg      | cfg_we                 | cfg_index, cfg_data
//
// A seed transaction is accepted directly in idle. A step transaction is accepted, then
// runs nine sequencer steps that pass five products through the single 32x32
// multiplier, with registered operands and a registered product.
// A blocked output holds the final step until the output register frees up.
// Reset (rst, synchronous) restores default coefficients and clears the point.
module rossler_euler_integrator #(
  parameter int unsigned FRAC_BITS = 24
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                func,
  input  logic signed [rei_pkg::COORD_W-1:0]  seed_x,
  input  logic signed [rei_pkg::COORD_W-1:0]  seed_y,
  input  logic signed [rei_pkg::COORD_W-1:0]  seed_z,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [rei_pkg::COORD_W-1:0]  out_x,
  output logic signed [rei_pkg::COORD_W-1:0]  out_y,
  output logic signed [rei_pkg::COORD_W-1:0]  out_z,
  output logic                                saturated,
  input  logic                                cfg_we,
  input  logic [rei_pkg::CIDX_W-1:0]          cfg_index,
  input  logic [rei_pkg::COORD_W-1:0]         cfg_data
);
  import rei_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  rei_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .func     (func),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  rei_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .seed_x    (seed_x),
    .seed_y    (seed_y),
    .seed_z    (seed_z),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_x     (out_x),
    .out_y     (out_y),
    .out_z     (out_z),
    .saturated (saturated)
  );

endmodule

FILE: tb/rossler_sample_checker.sv
`timescale 1ns / 1ps

// Watches the input, output and config ports of the Rossler integrator. It keeps its own
// copy of the point, the counters and the settings, predicts every sample, and compares
// each output transaction with the oldest predicted sample.
module rossler_sample_checker #(
  parameter int unsigned FRAC_BITS = 24
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  input  logic                                in_stall,
  input  logic                                func,
  input  logic signed [rei_pkg::COORD_W-1:0]  seed_x,
  input  logic signed [rei_pkg::COORD_W-1:0]  seed_y,
  input  logic signed [rei_pkg::COORD_W-1:0]  seed_z,
  input  logic                                out_valid,
  input  logic                                out_stall,
  input  logic signed [rei_pkg::COORD_W-1:0]  out_x,
  input  logic signed [rei_pkg::COORD_W-1:0]  out_y,
  input  logic signed [rei_pkg::COORD_W-1:0]  out_z,
  input  logic                                saturated,
  input  logic                                cfg_we,
  input  logic [rei_pkg::CIDX_W-1:0]          cfg_index,
  input  logic [rei_pkg::COORD_W-1:0]         cfg_data,
  output int                                  err_count,
  output int                                  pending
);
  import rei_pkg::*;

  localparam longint Q_ONE    = longint'(1) << FRAC_BITS;
  localparam longint ROUND_UP = longint'(1) << (FRAC_BITS - 1);
  localparam logic [WARM_W-1:0] STEP_CNT_MAX = '1;

  typedef struct {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic                      sat;
  } sample_t;

  sample_t expected_samples[$];

  // Settings
  logic [STEP_W-1:0]  h_reg;
  longint             a_reg, b_reg, c_reg;
  logic [WARM_W-1:0]  warm_reg;
  logic [DECIM_W-1:0] decim_reg;

  // Integrator state
  longint             px, py, pz;
  logic [WARM_W-1:0]  step_cnt;
  int                 decim_cnt;
  logic               sat_seen;

  int                 mismatches;
  longint             hl, d, t;
  logic [WARM_W-1:0]  idx;
  int                 period;
  sample_t            want;

  // Clamp to signed 32 bits, note any clamp in the sticky flag
  function automatic longint clip(longint v);
    if (v > S32_MAX) begin
      sat_seen = 1'b1;
      return S32_MAX;
    end
    if (v < S32_MIN) begin
      sat_seen = 1'b1;
      return S32_MIN;
    end
    return v;
  endfunction

  // Fixed point product, halves rounded up, then clamped
  function automatic longint fx_mul(longint m, longint n);
    longint p;
    p = m * n + ROUND_UP;
    return clip(p >>> FRAC_BITS);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      h_reg     = STEP_W'(Q_ONE / 100);
      a_reg     = Q_ONE / 5;
      b_reg     = Q_ONE / 5;
      c_reg     = (Q_ONE * 57) / 10;
      warm_reg  = WARMUP_RST;
      decim_reg = DECIM_RST;
      px        = 0;
      py        = 0;
      pz        = 0;
      step_cnt  = '0;
      decim_cnt = 0;
      sat_seen  = 1'b0;
      expected_samples.delete();
    end else begin
      // Output transaction against the oldest prediction
      if (out_valid && !out_stall) begin
        if (expected_samples.size() == 0) begin
          $error("unexpected sample: out_x %0d out_y %0d out_z %0d saturated %0b",
                 out_x, out_y, out_z, saturated);
          mismatches++;
        end else begin
          want = expected_samples.pop_front();
          if (out_x !== want.x) begin
            $error("out_x: expected %0d, actual %0d", want.x, out_x);
            mismatches++;
          end
          if (out_y !== want.y) begin
            $error("out_y: expected %0d, actual %0d", want.y, out_y);
            mismatches++;
          end
          if (out_z !== want.z) begin
            $error("out_z: expected %0d, actual %0d", want.z, out_z);
            mismatches++;
          end
          if (saturated !== want.sat) begin
            $error("saturated: expected %0b, actual %0b", want.sat, saturated);
            mismatches++;
          end
        end
      end

      // Register writes
      if (cfg_we) begin
        case (cfg_index)
          CFG_STEP_SIZE: h_reg     = cfg_data[STEP_W-1:0];
          CFG_COEF_A:    a_reg     = longint'(signed'(cfg_data));
          CFG_COEF_B:    b_reg     = longint'(signed'(cfg_data));
          CFG_COEF_C:    c_reg     = longint'(signed'(cfg_data));
          CFG_WARMUP:    warm_reg  = cfg_data[WARM_W-1:0];
          CFG_DECIM:     decim_reg = cfg_data[DECIM_W-1:0];
          default: ;
        endcase
      end

      // Input transaction: seed or one Euler step
      if (in_valid && !in_stall) begin
        if (func == FUNC_SEED) begin
          px        = longint'(seed_x);
          py        = longint'(seed_y);
          pz        = longint'(seed_z);
          step_cnt  = '0;
          decim_cnt = 0;
          sat_seen  = 1'b0;
        end else begin
          hl = longint'(h_reg);
          d  = clip(-py - pz);
          px = clip(px + fx_mul(hl, d));
          t  = fx_mul(a_reg, py);
          d  = clip(px + t);
          py = clip(py + fx_mul(hl, d));
          t  = clip(px - c_reg);
          t  = fx_mul(pz, t);
          d  = clip(b_reg + t);
          pz = clip(pz + fx_mul(hl, d));

          idx = step_cnt;
          if (step_cnt != STEP_CNT_MAX) step_cnt++;

          // Sampling after warmup, every period steps; zero period acts as one
          if (idx >= warm_reg) begin
            period = (decim_reg == '0) ? 1 : int'(decim_reg);
            if (decim_cnt >= period) decim_cnt = 0;
            if (decim_cnt == 0) begin
              want.x   = px[COORD_W-1:0];
              want.y   = py[COORD_W-1:0];
              want.z   = pz[COORD_W-1:0];
              want.sat = sat_seen;
              expected_samples.push_back(want);
            end
            decim_cnt++;
            if (decim_cnt >= period) decim_cnt = 0;
          end
        end
      end
    end
    pending   <= expected_samples.size();
    err_count <= mismatches;
  end

endmodule

FILE: tb/tb_rossler_euler_integrator.sv
`timescale 1ns / 1ps

module tb_rossler_euler_integrator;
  import rei_pkg::*;

  localparam int FRAC       = 24;
  localparam int Q_ONE      = 1 << FRAC;
  localparam int SETTLE_CYC = 16;
  localparam int N_PHASES   = 17;
  localparam int HOLD_AT    = 400;
  localparam int HOLD_CYC   = 300;
  localparam int TIMEOUT_NS = 20_000_000;
  // Spread of seeded points around the attractor, about +/-15.0
  localparam int SEED_SPAN  = 15 * Q_ONE;

  logic                       clk;
  logic                       rst;
  logic                       in_valid;
  logic                       in_stall;
  logic                       func;
  logic signed [COORD_W-1:0]  seed_x, seed_y, seed_z;
  logic                       out_valid;
  logic                       out_stall;
  logic signed [COORD_W-1:0]  out_x, out_y, out_z;
  logic                       saturated;
  logic                       cfg_we;
  logic [CIDX_W-1:0]          cfg_index;
  logic [COORD_W-1:0]         cfg_data;
  int                         err_count;
  int                         pending;

  int n_sent;
  bit hold_done;
  bit no_gaps;

  rossler_euler_integrator #(.FRAC_BITS(FRAC)) uut (.*);

  rossler_sample_checker #(.FRAC_BITS(FRAC)) chk (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Regression FAIL");
    $finish;
  end

  // Output side back-pressure: random stalls, plus one long hold once traffic is flowing
  initial begin
    int len, r;
    out_stall = 1'b0;
    hold_done = 1'b0;
    wait (rst == 1'b0);
    forever begin
      if (!hold_done && n_sent >= HOLD_AT) begin
        out_stall <= 1'b1;
        len = HOLD_CYC;
        hold_done = 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 45) begin
          out_stall <= 1'b0;
          len = $urandom_range(1, 40);
        end else if (r < 90) begin
          out_stall <= 1'b1;
          len = $urandom_range(1, 4);
        end else if (r < 98) begin
          out_stall <= 1'b1;
          len = $urandom_range(5, 30);
        end else begin
          out_stall <= 1'b1;
          len = $urandom_range(60, 200);
        end
      end
      repeat (len) @(posedge clk);
    end
  end

  // Random pause on the input side, mostly none
  task automatic idle_gap();
    int r, n;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 60) n = 0;
    else if (r < 88) n = $urandom_range(1, 3);
    else if (r < 97) n = $urandom_range(4, 12);
    else n = $urandom_range(20, 60);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // One input transaction, held until accepted
  task automatic offer(logic f, logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y,
                       logic signed [COORD_W-1:0] z);
    in_valid <= 1'b1;
    func     <= f;
    seed_x   <= x;
    seed_y   <= y;
    seed_z   <= z;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n_sent++;
    idle_gap();
  endtask

  // Step items carry random, ignored seed fields
  task automatic steps(int n);
    repeat (n) offer(FUNC_STEP, $urandom, $urandom, $urandom);
  endtask

  task automatic cfg_write(logic [CIDX_W-1:0] idx, logic [COORD_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  // Wait until every predicted sample is out and any trailing step is done
  task automatic quiesce();
    in_valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  function automatic logic signed [COORD_W-1:0] near_attractor();
    return int'($urandom_range(0, 2 * SEED_SPAN)) - SEED_SPAN;
  endfunction

  // New settings between phases, each register written half the time
  task automatic random_settings();
    int r;
    if ($urandom_range(0, 1)) begin
      r = $urandom_range(0, 9);
      if (r < 7) cfg_write(CFG_STEP_SIZE, $urandom_range(16777, 838860));
      else if (r == 7) cfg_write(CFG_STEP_SIZE, $urandom);
      else if (r == 8) cfg_write(CFG_STEP_SIZE, '0);
      else cfg_write(CFG_STEP_SIZE, 32'h7FFF_FFFF);
    end
    if ($urandom_range(0, 1)) begin
      if ($urandom_range(0, 9) < 7) cfg_write(CFG_COEF_A, $urandom_range(1677721, 6710886));
      else cfg_write(CFG_COEF_A, $urandom);
    end
    if ($urandom_range(0, 1)) begin
      if ($urandom_range(0, 9) < 7) cfg_write(CFG_COEF_B, $urandom_range(1677721, 6710886));
      else cfg_write(CFG_COEF_B, $urandom);
    end
    if ($urandom_range(0, 1)) begin
      if ($urandom_range(0, 9) < 7) cfg_write(CFG_COEF_C, $urandom_range(4 * Q_ONE, 8 * Q_ONE));
      else cfg_write(CFG_COEF_C, $urandom);
    end
    if ($urandom_range(0, 1)) begin
      if ($urandom_range(0, 19) == 0) cfg_write(CFG_WARMUP, $urandom);
      else cfg_write(CFG_WARMUP, $urandom_range(0, 15));
    end
    if ($urandom_range(0, 1)) begin
      r = $urandom_range(0, 19);
      if (r == 0) cfg_write(CFG_DECIM, $urandom);
      else if (r == 1) cfg_write(CFG_DECIM, '0);
      else cfg_write(CFG_DECIM, $urandom_range(1, 4));
    end
    cfg_we <= 1'b0;
  endtask

  initial begin
    int budget, n, r;
    rst       = 1'b1;
    in_valid  = 1'b0;
    func      = FUNC_SEED;
    seed_x    = '0;
    seed_y    = '0;
    seed_z    = '0;
    cfg_we    = 1'b0;
    cfg_index = CFG_STEP_SIZE;
    cfg_data  = '0;
    n_sent    = 0;
    no_gaps   = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: long warmup, so no samples; first step runs from the cleared point
    steps(1);
    offer(FUNC_SEED, Q_ONE, 2 * Q_ONE, 3 * Q_ONE);
    steps(1);
    quiesce();

    // Sample every step, seeds at the field extremes
    cfg_write(CFG_WARMUP, '0);
    cfg_write(CFG_DECIM, 32'd1);
    cfg_we <= 1'b0;
    offer(FUNC_SEED, 5 * Q_ONE, -3 * Q_ONE, Q_ONE / 2);
    steps(3);
    offer(FUNC_SEED, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    steps(2);
    offer(FUNC_SEED, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
    steps(1);
    offer(FUNC_SEED, '0, '0, '0);
    steps(1);
    quiesce();

    // Largest step and extreme coefficients; zero decimation samples every step
    cfg_write(CFG_STEP_SIZE, 32'h7FFF_FFFF);
    cfg_write(CFG_COEF_A, 32'h8000_0000);
    cfg_write(CFG_COEF_B, 32'h7FFF_FFFF);
    cfg_write(CFG_COEF_C, 32'h8000_0000);
    cfg_write(CFG_DECIM, '0);
    cfg_we <= 1'b0;
    offer(FUNC_SEED, Q_ONE, Q_ONE, Q_ONE);
    steps(2);
    quiesce();

    // Zero step, opposite extremes, largest warmup and decimation
    cfg_write(CFG_STEP_SIZE, '0);
    cfg_write(CFG_COEF_A, 32'h7FFF_FFFF);
    cfg_write(CFG_COEF_B, 32'h8000_0000);
    cfg_write(CFG_COEF_C, 32'h7FFF_FFFF);
    cfg_write(CFG_WARMUP, 32'h00FF_FFFF);
    cfg_write(CFG_DECIM, 32'h0000_FFFF);
    cfg_we <= 1'b0;
    steps(2);
    quiesce();

    // Decimation shrunk mid run: a count past the new period wraps
    cfg_write(CFG_STEP_SIZE, Q_ONE / 100);
    cfg_write(CFG_COEF_A, Q_ONE / 5);
    cfg_write(CFG_COEF_B, Q_ONE / 5);
    cfg_write(CFG_COEF_C, (Q_ONE / 10) * 57);
    cfg_write(CFG_WARMUP, '0);
    cfg_write(CFG_DECIM, 32'd5);
    cfg_we <= 1'b0;
    offer(FUNC_SEED, near_attractor(), near_attractor(), near_attractor());
    steps(3);
    quiesce();
    cfg_write(CFG_DECIM, 32'd2);
    cfg_we <= 1'b0;
    steps(2);

    // Random phases: mostly seeded trajectories, some noise
    for (int ph = 0; ph < N_PHASES; ph++) begin
      quiesce();
      random_settings();
      no_gaps = ($urandom_range(0, 3) == 0);
      budget = 45;
      while (budget > 0) begin
        r = $urandom_range(0, 99);
        if (r < 85) begin
          n = $urandom_range(4, 30);
          offer(FUNC_SEED, near_attractor(), near_attractor(), near_attractor());
          steps(n);
          budget -= n + 1;
        end else if (r < 93) begin
          n = $urandom_range(1, 4);
          offer(FUNC_SEED, $urandom, $urandom, $urandom);
          steps(n);
          budget -= n + 1;
        end else begin
          steps(1);
          budget -= 1;
        end
      end
    end
    no_gaps = 1'b0;

    quiesce();
    repeat (20) @(posedge clk);
    if (err_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
